FILE: sv/glos_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glos_pkg: shared types and constants of the grid line-of-sight checker
// Field widths, register reset values, beat codes and sequencer states.
// ----------------------------------------------------------------------------
package glos_pkg;

  // Fixed field widths
  localparam int COORD_W    = 8;   // cell coordinates of a beat
  localparam int VALUE_W    = 8;   // cell value of a write beat
  localparam int MODE_W     = 2;
  localparam int DIM_W      = 9;   // map_width / map_height
  localparam int STEP_W     = 8;
  localparam int LEVEL_W    = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  // Walk datapath widths
  localparam int PROD_W  = 16;     // |dminor| * stride
  localparam int MAJ_W   = 10;     // major coordinate, including overshoot
  localparam int QUO_W   = 11;     // signed floor quotient of the minor coordinate
  localparam int QINC_W  = 10;     // signed per-step quotient increment

  // Default store geometry
  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;
  localparam int DEF_CELL_BITS  = 8;

  // Register reset values
  localparam logic [DIM_W-1:0]   RST_MAP_WIDTH   = 9'd256;
  localparam logic [DIM_W-1:0]   RST_MAP_HEIGHT  = 9'd256;
  localparam logic [STEP_W-1:0]  RST_STEP_SIZE   = 8'd1;
  localparam logic [LEVEL_W-1:0] RST_BLOCK_LEVEL = 8'd200;

  // A single-cell check passes only at this value
  localparam int FREE_LEVEL = 255;

  typedef enum logic [MODE_W-1:0] {
    MODE_WRITE = 2'd0,
    MODE_SEG   = 2'd1,
    MODE_CELL  = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAP_WIDTH   = 2'd0,
    CFG_MAP_HEIGHT  = 2'd1,
    CFG_STEP_SIZE   = 2'd2,
    CFG_BLOCK_LEVEL = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DIV,
    ST_INIT,
    ST_STEP,
    ST_CELL_RD,
    ST_CELL_CMP,
    ST_FIN
  } state_e;

endpackage

FILE: sv/grid_line_of_sight_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_line_of_sight_check: occupancy-grid line collision checker
// Holds a cell map in an on-chip memory and answers segment checks (walk
// along the major axis at a set stride) and single-cell checks.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-------------------------------
//  in      | sink      | in_valid_i / in_stall_o | mode, cell_x/y/value, start/end
//  out     | source    | out_valid_o / out_stall_i | is_free, was_segment
//  cfg     | sink      | cfg_we_i                | cfg_idx_i, cfg_data_i
//
//  Map write: the block stays idle and takes a new request right away. Cell check:
//  a map read, a compare, then the finish. Segment check: a setup multiply,
//  the restoring divider, then one map read per cycle (at most 256 cells read)
//  through the single memory read port. Equal endpoints go straight to the finish as free.
//  Reset clears control state and configuration registers; map contents
//  are undefined until written and get no clearing pass.
//  A waiting result does not block intake; only the finish of the next check
//  waits on out_stall_i.
// ----------------------------------------------------------------------------
module grid_line_of_sight_check #(
  parameter int MAX_WIDTH  = glos_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = glos_pkg::DEF_MAX_HEIGHT,
  parameter int CELL_BITS  = glos_pkg::DEF_CELL_BITS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration port
  input  logic                             cfg_we_i,
  input  logic [glos_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [glos_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  // input channel
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [glos_pkg::MODE_W-1:0]      mode_i,
  input  logic [glos_pkg::COORD_W-1:0]     cell_x_i,
  input  logic [glos_pkg::COORD_W-1:0]     cell_y_i,
  input  logic [glos_pkg::VALUE_W-1:0]     cell_value_i,
  input  logic [glos_pkg::COORD_W-1:0]     start_x_i,
  input  logic [glos_pkg::COORD_W-1:0]     start_y_i,
  input  logic [glos_pkg::COORD_W-1:0]     end_x_i,
  input  logic [glos_pkg::COORD_W-1:0]     end_y_i,
  // output channel
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             is_free_o,
  output logic                             was_segment_o
);

  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int AW    = XW + YW;
  localparam int DEPTH = 2 ** AW;
  localparam int LIMW0 = $clog2(MAX_WIDTH + 1) > $clog2(MAX_HEIGHT + 1) ?
                         $clog2(MAX_WIDTH + 1) : $clog2(MAX_HEIGHT + 1);
  localparam int LIMW  = LIMW0 > glos_pkg::DIM_W ? LIMW0 : glos_pkg::DIM_W;
  localparam int CMPW  = (LIMW > glos_pkg::QUO_W ? LIMW : glos_pkg::QUO_W) + 1;
  localparam int CMPV  = CELL_BITS > glos_pkg::VALUE_W ? CELL_BITS : glos_pkg::VALUE_W;
  localparam int CNT_W = $clog2(glos_pkg::PROD_W);

  localparam int CW = glos_pkg::COORD_W;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [glos_pkg::DIM_W-1:0]   map_width_q, map_height_q;
  logic [glos_pkg::STEP_W-1:0]  step_size_q;
  logic [glos_pkg::LEVEL_W-1:0] block_level_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_width_q   <= glos_pkg::RST_MAP_WIDTH;
      map_height_q  <= glos_pkg::RST_MAP_HEIGHT;
      step_size_q   <= glos_pkg::RST_STEP_SIZE;
      block_level_q <= glos_pkg::RST_BLOCK_LEVEL;
    end else if (cfg_we_i) begin
      unique case (glos_pkg::cfg_idx_e'(cfg_idx_i))
        glos_pkg::CFG_MAP_WIDTH:   map_width_q   <= cfg_data_i;
        glos_pkg::CFG_MAP_HEIGHT:  map_height_q  <= cfg_data_i;
        glos_pkg::CFG_STEP_SIZE:   step_size_q   <= cfg_data_i[glos_pkg::STEP_W-1:0];
        glos_pkg::CFG_BLOCK_LEVEL: block_level_q <= cfg_data_i[glos_pkg::LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  // Map size in use
  logic [LIMW-1:0] eff_w, eff_h;
  assign eff_w = (LIMW'(map_width_q) < LIMW'(MAX_WIDTH)) ? LIMW'(map_width_q)
                                                         : LIMW'(MAX_WIDTH);
  assign eff_h = (LIMW'(map_height_q) < LIMW'(MAX_HEIGHT)) ? LIMW'(map_height_q)
                                                           : LIMW'(MAX_HEIGHT);

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  glos_pkg::state_e state_q, state_d;

  logic [CW-1:0]                 sx_q, sy_q, ex_q, ey_q;
  logic [CW-1:0]                 sx_d, sy_d, ex_d, ey_d;
  logic                          major_x_q, major_x_d;
  logic                          neg_q, neg_d;
  logic [CW-1:0]                 dmaj_q, dmaj_d;
  logic [CW-1:0]                 step_q, step_d;
  logic [CW-1:0]                 s_maj_q, s_maj_d, s_min_q, s_min_d;
  logic [glos_pkg::MAJ_W-1:0]    e_lim_q, e_lim_d;
  logic [glos_pkg::PROD_W-1:0]   dvd_q, dvd_d;
  logic [CW:0]                   rem_q, rem_d;
  logic [CNT_W-1:0]              cnt_q, cnt_d;
  logic [glos_pkg::QINC_W-1:0]   q_inc_q, q_inc_d;
  logic [CW-1:0]                 r_inc_q, r_inc_d;
  logic [glos_pkg::QUO_W-1:0]    quo_q, quo_d;
  logic [CW-1:0]                 frac_q, frac_d;
  logic [glos_pkg::MAJ_W-1:0]    c_q, c_d;
  logic                          pend_q, pend_d;
  logic                          res_free_q, res_free_d;
  logic                          res_seg_q, res_seg_d;
  logic                          out_valid_q, out_valid_d;
  logic                          is_free_q, is_free_d;
  logic                          was_seg_q, was_seg_d;

  // Memory port controls
  logic                  wr_en, rd_en;
  logic [AW-1:0]         wr_addr, rd_addr;
  logic [CELL_BITS-1:0]  wr_data, rd_q;

  logic in_acc;
  assign in_stall_o = (state_q != glos_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  // --------------------------------------------------------------------------
  // Setup arithmetic: endpoint order, deltas and the stride product
  // --------------------------------------------------------------------------
  logic [CW:0]    dx, dy;
  logic [CW-1:0]  adx, ady;
  logic           su_major_x;
  logic [CW-1:0]  su_s_maj, su_s_min, su_e_maj, su_e_min;
  logic [CW:0]    su_dmin;
  logic [CW-1:0]  su_abs_dmin, su_step;

  always_comb begin
    dx  = {1'b0, sx_q} - {1'b0, ex_q};
    dy  = {1'b0, sy_q} - {1'b0, ey_q};
    adx = dx[CW] ? CW'(-dx) : dx[CW-1:0];
    ady = dy[CW] ? CW'(-dy) : dy[CW-1:0];
    su_major_x = adx > ady;
    if (su_major_x) begin
      if (sx_q < ex_q) begin
        su_s_maj = sx_q; su_s_min = sy_q; su_e_maj = ex_q; su_e_min = ey_q;
      end else begin
        su_s_maj = ex_q; su_s_min = ey_q; su_e_maj = sx_q; su_e_min = sy_q;
      end
    end else begin
      if (sy_q < ey_q) begin
        su_s_maj = sy_q; su_s_min = sx_q; su_e_maj = ey_q; su_e_min = ex_q;
      end else begin
        su_s_maj = ey_q; su_s_min = ex_q; su_e_maj = sy_q; su_e_min = sx_q;
      end
    end
    su_dmin     = {1'b0, su_e_min} - {1'b0, su_s_min};
    su_abs_dmin = su_dmin[CW] ? CW'(-su_dmin) : su_dmin[CW-1:0];
    su_step     = (step_size_q == '0) ? CW'(1) : step_size_q;
  end

  // --------------------------------------------------------------------------
  // Restoring divider step
  // --------------------------------------------------------------------------
  logic [CW:0] rem_sh;
  logic        div_ge;
  assign rem_sh = {rem_q[CW-1:0], dvd_q[glos_pkg::PROD_W-1]};
  assign div_ge = rem_sh >= {1'b0, dmaj_q};

  // --------------------------------------------------------------------------
  // Walk step: minor coordinate, bounds, next position
  // --------------------------------------------------------------------------
  logic [glos_pkg::QUO_W-1:0] m_s;
  logic                       m_neg, walk_end, off_map, blk_prev;
  logic [LIMW-1:0]            lim_maj, lim_min;
  logic [CW:0]                r_sum;
  logic                       r_wrap;
  logic [glos_pkg::QUO_W-1:0] q_step;
  logic [glos_pkg::QUO_W-1:0] x_full, y_full;
  logic [CMPV-1:0]            rd_ext, lvl_ext;

  always_comb begin
    // truncation toward zero from floor quotient and remainder
    m_s = (quo_q[glos_pkg::QUO_W-1] && frac_q != '0) ? quo_q + 1'b1 : quo_q;
    m_neg    = m_s[glos_pkg::QUO_W-1];
    lim_maj  = major_x_q ? eff_w : eff_h;
    lim_min  = major_x_q ? eff_h : eff_w;
    walk_end = c_q >= e_lim_q;
    off_map  = walk_end || m_neg || (CMPW'(c_q) >= CMPW'(lim_maj)) ||
               (CMPW'(m_s) >= CMPW'(lim_min));
    rd_ext   = CMPV'(rd_q);
    lvl_ext  = CMPV'(block_level_q);
    blk_prev = pend_q && (rd_ext < lvl_ext);
    r_sum    = {1'b0, frac_q} + {1'b0, r_inc_q};
    r_wrap   = r_sum >= {1'b0, dmaj_q};
    q_step   = quo_q + {q_inc_q[glos_pkg::QINC_W-1], q_inc_q} +
               {{(glos_pkg::QUO_W-1){1'b0}}, r_wrap};
    x_full   = major_x_q ? {1'b0, c_q} : m_s;
    y_full   = major_x_q ? m_s : {1'b0, c_q};
  end

  // --------------------------------------------------------------------------
  // Sequencer: next state, datapath updates, memory controls
  // --------------------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    sx_d = sx_q; sy_d = sy_q; ex_d = ex_q; ey_d = ey_q;
    major_x_d   = major_x_q;
    neg_d       = neg_q;
    dmaj_d      = dmaj_q;
    step_d      = step_q;
    s_maj_d     = s_maj_q;
    s_min_d     = s_min_q;
    e_lim_d     = e_lim_q;
    dvd_d       = dvd_q;
    rem_d       = rem_q;
    cnt_d       = cnt_q;
    q_inc_d     = q_inc_q;
    r_inc_d     = r_inc_q;
    quo_d       = quo_q;
    frac_d      = frac_q;
    c_d         = c_q;
    pend_d      = pend_q;
    res_free_d  = res_free_q;
    res_seg_d   = res_seg_q;
    out_valid_d = out_valid_q && out_stall_i;
    is_free_d   = is_free_q;
    was_seg_d   = was_seg_q;
    wr_en       = 1'b0;
    wr_addr     = {XW'(cell_x_i), YW'(cell_y_i)};
    wr_data     = CELL_BITS'(cell_value_i);
    rd_en       = 1'b0;
    rd_addr     = {XW'(x_full), YW'(y_full)};

    unique case (state_q)
      glos_pkg::ST_IDLE: begin
        if (in_acc) begin
          sx_d = start_x_i; sy_d = start_y_i; ex_d = end_x_i; ey_d = end_y_i;
          unique case (glos_pkg::mode_e'(mode_i))
            glos_pkg::MODE_WRITE: begin
              wr_en = (CMPW'(cell_x_i) < CMPW'(MAX_WIDTH)) &&
                      (CMPW'(cell_y_i) < CMPW'(MAX_HEIGHT));
            end
            glos_pkg::MODE_SEG:  state_d = glos_pkg::ST_SETUP;
            glos_pkg::MODE_CELL: state_d = glos_pkg::ST_CELL_RD;
            glos_pkg::MODE_NONE: ;
            default: ;
          endcase
        end
      end

      glos_pkg::ST_SETUP: begin
        res_seg_d = 1'b1;
        if (adx == '0 && ady == '0) begin
          res_free_d = 1'b1;
          state_d    = glos_pkg::ST_FIN;
        end else begin
          major_x_d = su_major_x;
          s_maj_d   = su_s_maj;
          s_min_d   = su_s_min;
          dmaj_d    = su_e_maj - su_s_maj;
          neg_d     = su_dmin[CW];
          step_d    = su_step;
          e_lim_d   = glos_pkg::MAJ_W'(su_e_maj) + glos_pkg::MAJ_W'(su_step);
          dvd_d     = glos_pkg::PROD_W'(su_abs_dmin) * glos_pkg::PROD_W'(su_step);
          rem_d     = '0;
          cnt_d     = '0;
          state_d   = glos_pkg::ST_DIV;
        end
      end

      // one quotient bit per cycle; dvd_q ends as the quotient
      glos_pkg::ST_DIV: begin
        rem_d = div_ge ? rem_sh - {1'b0, dmaj_q} : rem_sh;
        dvd_d = {dvd_q[glos_pkg::PROD_W-2:0], div_ge};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(glos_pkg::PROD_W - 1)) state_d = glos_pkg::ST_INIT;
      end

      // floor form of the per-step increment
      glos_pkg::ST_INIT: begin
        if (!neg_q) begin
          q_inc_d = glos_pkg::QINC_W'(dvd_q[CW-1:0]);
          r_inc_d = rem_q[CW-1:0];
        end else if (rem_q == '0) begin
          q_inc_d = glos_pkg::QINC_W'(-glos_pkg::QINC_W'(dvd_q[CW-1:0]));
          r_inc_d = '0;
        end else begin
          q_inc_d = glos_pkg::QINC_W'(~glos_pkg::QINC_W'(dvd_q[CW-1:0]));
          r_inc_d = dmaj_q - rem_q[CW-1:0];
        end
        quo_d   = glos_pkg::QUO_W'(s_min_q);
        frac_d  = '0;
        c_d     = glos_pkg::MAJ_W'(s_maj_q);
        pend_d  = 1'b0;
        state_d = glos_pkg::ST_STEP;
      end

      // check the previous read and issue the next one in the same cycle
      glos_pkg::ST_STEP: begin
        if (blk_prev) begin
          res_free_d = 1'b0;
          pend_d     = 1'b0;
          state_d    = glos_pkg::ST_FIN;
        end else if (off_map) begin
          res_free_d = 1'b1;
          pend_d     = 1'b0;
          state_d    = glos_pkg::ST_FIN;
        end else begin
          rd_en  = 1'b1;
          pend_d = 1'b1;
          c_d    = c_q + glos_pkg::MAJ_W'(step_q);
          frac_d = r_wrap ? CW'(r_sum - {1'b0, dmaj_q}) : r_sum[CW-1:0];
          quo_d  = q_step;
        end
      end

      glos_pkg::ST_CELL_RD: begin
        res_seg_d = 1'b0;
        rd_addr   = {XW'(sx_q), YW'(sy_q)};
        if ((CMPW'(sx_q) < CMPW'(eff_w)) && (CMPW'(sy_q) < CMPW'(eff_h))) begin
          rd_en   = 1'b1;
          state_d = glos_pkg::ST_CELL_CMP;
        end else begin
          res_free_d = 1'b0;
          state_d    = glos_pkg::ST_FIN;
        end
      end

      glos_pkg::ST_CELL_CMP: begin
        res_free_d = rd_ext >= CMPV'(glos_pkg::FREE_LEVEL);
        state_d    = glos_pkg::ST_FIN;
      end

      // hand the answer to the output register once it is free
      glos_pkg::ST_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          is_free_d   = res_free_q;
          was_seg_d   = res_seg_q;
          state_d     = glos_pkg::ST_IDLE;
        end
      end

      default: state_d = glos_pkg::ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= glos_pkg::ST_IDLE;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    sx_q       <= sx_d;
    sy_q       <= sy_d;
    ex_q       <= ex_d;
    ey_q       <= ey_d;
    major_x_q  <= major_x_d;
    neg_q      <= neg_d;
    dmaj_q     <= dmaj_d;
    step_q     <= step_d;
    s_maj_q    <= s_maj_d;
    s_min_q    <= s_min_d;
    e_lim_q    <= e_lim_d;
    dvd_q      <= dvd_d;
    rem_q      <= rem_d;
    q_inc_q    <= q_inc_d;
    r_inc_q    <= r_inc_d;
    quo_q      <= quo_d;
    frac_q     <= frac_d;
    c_q        <= c_d;
    res_free_q <= res_free_d;
    res_seg_q  <= res_seg_d;
    is_free_q  <= is_free_d;
    was_seg_q  <= was_seg_d;
  end

  // --------------------------------------------------------------------------
  // Occupancy map: one write port, one registered read port
  // --------------------------------------------------------------------------
  logic [CELL_BITS-1:0] map_mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en) map_mem[wr_addr] <= wr_data;
    if (rd_en) rd_q <= map_mem[rd_addr];
  end

  assign out_valid_o   = out_valid_q;
  assign is_free_o     = is_free_q;
  assign was_segment_o = was_seg_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_div_rem_below_divisor : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == glos_pkg::ST_DIV) |-> (rem_q < {1'b0, dmaj_q}))
    else $error("divider remainder not below divisor");

  a_walk_frac_below_dmaj : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == glos_pkg::ST_STEP) |-> (frac_q < dmaj_q))
    else $error("walk remainder out of range");

  a_walk_advances : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == glos_pkg::ST_STEP && rd_en) |=>
      (state_q == glos_pkg::ST_STEP && c_q > $past(c_q)))
    else $error("walk did not advance after a map read");

  a_inc_within_stride : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == glos_pkg::ST_STEP && !q_inc_q[glos_pkg::QINC_W-1]) |->
      (q_inc_q <= glos_pkg::QINC_W'(step_q)))
    else $error("minor increment exceeds stride");

endmodule
